>>> src/tlls_pkg.sv
// Shared types and constants for the tail loop length search.
`default_nettype none
package tlls_pkg;
  localparam int ADDR_BITS = 16;
  localparam int CNT_BITS = 17;
  localparam int SAMPLE_BITS = 16;
  localparam int SCORE_BITS = 52;
  localparam int CFG_BITS = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LOOP = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LOOP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CMP_LEN  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRATEGY = 2'd3;

  localparam logic signed [SCORE_BITS-1:0] SCORE_TOP = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SCORE_BOTTOM = {1'b1, {(SCORE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_LOAD, ST_CHECK, ST_SIZE, ST_MOD, ST_READ, ST_WAIT, ST_MAC, ST_NEXT, ST_DONE
  } state_t;

  // control from sequencer to MAC datapath
  typedef struct packed {
    logic clear;
    logic enable;
    logic corr;
  } mac_ctrl_t;
endpackage
`default_nettype wire

>>> src/tlls_mac.sv
// Shared multiply-accumulate unit with saturating 52-bit accumulator.
`default_nettype none
module tlls_mac
  import tlls_pkg::*;
(
  input  wire logic                          clk,
  input  wire mac_ctrl_t                     ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] a,
  input  wire logic signed [SAMPLE_BITS-1:0] b,
  output logic signed [SCORE_BITS-1:0]       acc
);
  logic signed [SAMPLE_BITS:0]     diff;
  logic signed [SAMPLE_BITS:0]     op_x;
  logic signed [SAMPLE_BITS:0]     op_y;
  logic signed [2*SAMPLE_BITS+1:0] term;
  logic signed [SCORE_BITS:0]      sum;

  // product or squared difference
  always_comb begin
    diff = SAMPLE_BITS'(0) + ($signed({a[SAMPLE_BITS-1], a}) - $signed({b[SAMPLE_BITS-1], b}));
    op_x = ctrl.corr ? {a[SAMPLE_BITS-1], a} : diff;
    op_y = ctrl.corr ? {b[SAMPLE_BITS-1], b} : diff;
    term = op_x * op_y;
    sum  = {acc[SCORE_BITS-1], acc} + (SCORE_BITS+1)'(term);
  end

  // saturating accumulate
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.enable) begin
      if (sum[SCORE_BITS] != sum[SCORE_BITS-1])
        acc <= sum[SCORE_BITS] ? SCORE_BOTTOM : SCORE_TOP;
      else
        acc <= sum[SCORE_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

>>> src/tail_loop_length_search.sv
// Top level: sample store, search sequencer and result register.
//
// Usage: samples arrive on sample/last with start; a transaction is accepted
// when start is high and busy is low. Plain samples keep busy low, so they
// can follow back to back.
// A sample with last set starts the search. Busy rises for a check state,
// then per loop size come a setup state, the compare_length mod size
// reduction (one subtract per cycle), for each compared pair a store read of
// the loop sample, a read of the compared sample and a MAC step, and last a
// compare state. A final setup state and a done state close the search;
// busy drops and the result appears on the output ports, held there, with
// done high for a single cycle in the cycle that the result appears.
// Invalid settings: after the check state, status 1 with done in the next cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be made while busy is low. Reset clears control state and the
// registers to their defaults; the store needs no clearing. The receiver
// cannot stall: done is a single-cycle strobe.
`default_nettype none
module tail_loop_length_search
  import tlls_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          last,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  output logic                               done,
  output logic [CNT_BITS-1:0]                loop_begin,
  output logic [ADDR_BITS-1:0]               loop_end,
  output logic [ADDR_BITS-1:0]               loop_size,
  output logic signed [SCORE_BITS-1:0]       best_score,
  output logic                               status
);
  logic [15:0] min_size, max_size, cmp_len;
  logic        strat;

  logic signed [SAMPLE_BITS-1:0] store [0:(1<<ADDR_BITS)-1];
  logic signed [SAMPLE_BITS-1:0] rd_data, a_reg;
  logic [ADDR_BITS-1:0]          rd_addr;

  state_t state, state_next;
  logic [CNT_BITS-1:0] count, n;
  logic [CNT_BITS-1:0] upper, trial, ls, pos, idx, rem;
  logic [CNT_BITS-1:0] upper_calc;
  logic [CNT_BITS-1:0] pair_left;
  logic                phase;
  logic                corr;
  logic                cfg_bad;
  logic [ADDR_BITS-1:0] best_sz;
  logic signed [SCORE_BITS-1:0] best_val, acc;
  mac_ctrl_t ctrl;
  logic accept;

  assign accept = start && !busy;
  assign busy = (state != ST_LOAD);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_size <= 16'd1;
      max_size <= 16'd0;
      cmp_len  <= 16'd1024;
      strat    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LOOP: min_size <= cfg_data;
        REG_MAX_LOOP: max_size <= cfg_data;
        REG_CMP_LEN:  cmp_len  <= cfg_data;
        REG_STRATEGY: strat    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // settings check against the block length
  assign upper_calc = (max_size == 16'd0) ? n - CNT_BITS'(1) - {1'b0, cmp_len}
                                          : {1'b0, max_size};
  assign cfg_bad = (min_size == 16'd0) || ({1'b0, cmp_len} + CNT_BITS'(1) >= n) ||
                   (upper_calc < {1'b0, min_size}) ||
                   ({1'b0, cmp_len} + upper_calc >= n);

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && !count[CNT_BITS-1])
      store[count[ADDR_BITS-1:0]] <= sample;
    rd_data <= store[rd_addr];
  end
  assign rd_addr = phase ? idx[ADDR_BITS-1:0] : pos[ADDR_BITS-1:0];

  tlls_mac u_mac (.clk(clk), .ctrl(ctrl), .a(a_reg), .b(rd_data), .acc(acc));

  // sequencer next state
  always_comb begin
    state_next = state;
    ctrl = '{clear: 1'b0, enable: 1'b0, corr: corr};
    case (state)
      ST_LOAD:  if (accept && last) state_next = ST_CHECK;
      ST_CHECK: state_next = cfg_bad ? ST_LOAD : ST_SIZE;
      ST_SIZE: begin
        ctrl.clear = 1'b1;
        state_next = (trial < upper) ? ST_MOD : ST_DONE;
      end
      ST_MOD:  if (rem < trial) state_next = (pair_left == '0) ? ST_NEXT : ST_READ;
      ST_READ: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_MAC;
      ST_MAC: begin
        ctrl.enable = 1'b1;
        state_next = (pair_left == CNT_BITS'(1)) ? ST_NEXT : ST_READ;
      end
      ST_NEXT: state_next = ST_SIZE;
      ST_DONE: state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= (state == ST_DONE) || (state == ST_CHECK && cfg_bad);
      case (state)
        ST_LOAD: begin
          phase <= 1'b0;
          if (accept) begin
            if (last) begin
              n <= count[CNT_BITS-1] ? count : count + CNT_BITS'(1);
              count <= '0;
            end else if (!count[CNT_BITS-1]) begin
              count <= count + CNT_BITS'(1);
            end
          end
        end
        ST_CHECK: begin
          corr    <= strat;
          trial   <= {1'b0, min_size};
          best_sz <= '0;
          best_val <= strat ? '0 : SCORE_TOP;
          upper <= upper_calc;
          if (cfg_bad) begin
            status <= 1'b1;
            loop_begin <= '0;
            loop_end <= '0;
            loop_size <= '0;
            best_score <= '0;
          end
        end
        ST_SIZE: begin
          ls  <= n - trial;
          rem <= {1'b0, cmp_len};
          pair_left <= {1'b0, cmp_len};
          idx <= n - trial - {1'b0, cmp_len};
        end
        ST_MOD: begin
          if (rem >= trial) rem <= rem - trial;
          else pos <= (rem == '0) ? ls : ls + trial - rem;
          phase <= 1'b0;
        end
        ST_READ: phase <= 1'b1;
        ST_WAIT: begin
          a_reg <= rd_data;
          phase <= 1'b0;
          idx <= idx + CNT_BITS'(1);
          pos <= (pos + CNT_BITS'(1) >= n) ? ls : pos + CNT_BITS'(1);
        end
        ST_MAC: pair_left <= pair_left - CNT_BITS'(1);
        ST_NEXT: begin
          if (corr ? (acc > best_val) : (acc < best_val)) begin
            best_val <= acc;
            best_sz  <= trial[ADDR_BITS-1:0];
          end
          trial <= trial + CNT_BITS'(1);
        end
        ST_DONE: begin
          status <= 1'b0;
          loop_begin <= n - {1'b0, best_sz};
          loop_end <= n[ADDR_BITS-1:0] - ADDR_BITS'(1);
          loop_size <= best_sz;
          best_score <= best_val;
        end
        default: ;
      endcase
    end
  end

  // a result strobe never lasts more than one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  // the MAC only accumulates inside a search
  a_mac_busy: assert property (@(posedge clk) disable iff (rst) ctrl.enable |-> busy)
    else $error("mac while idle");
  // search starts only from an accepted last sample
  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && last))
    else $error("bad start");
endmodule
`default_nettype wire
